FILE: rtl/ple_pkg.sv
// shared types, codes and defaults for the positional list engine
package ple_pkg;

   // default sizing
   localparam int PLE_CAPACITY   = 64;
   localparam int PLE_DATA_WIDTH = 32;

   // request action codes
   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_FIND   = 2'd2,
      ACT_SEARCH = 2'd3
   } action_type;

   // response status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic eval;   // cells capture read and compare results
      logic ins;    // shift up from the slot and write the new word
      logic del;    // shift down from the slot
      logic rd;     // drive the word held at the slot
      logic srch;   // compare the held word with the request word
   } ple_ctrl_type;

endpackage

FILE: rtl/ple_cell.sv
// one list cell: holds one entry, shifts with its neighbors, reads and compares
module ple_cell import ple_pkg::*; #(
   parameter int DATA_WIDTH = PLE_DATA_WIDTH,
   parameter int CAPACITY   = PLE_CAPACITY,
   parameter int INDEX      = 0
) (
   input  logic                               clock,
   input  ple_ctrl_type                       ctrl,
   input  logic [$clog2(CAPACITY)-1:0]        slot,
   input  logic [$clog2(CAPACITY+1)-1:0]      count,
   input  logic [DATA_WIDTH-1:0]              val,
   input  logic [DATA_WIDTH-1:0]              left_data,
   input  logic [DATA_WIDTH-1:0]              right_data,
   output logic [DATA_WIDTH-1:0]              data,
   output logic [DATA_WIDTH-1:0]              rd_data,
   output logic                               hit
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [DATA_WIDTH-1:0] rd_ff, rd_in;
   logic                  hit_ff, hit_in;
   logic                  at_slot, above_slot, in_list;

   // position of this cell relative to the addressed slot
   assign at_slot    = (slot == AW'(INDEX));
   assign above_slot = (AW'(INDEX) > slot);
   assign in_list    = (count > CW'(INDEX));

   // next entry value: hold, shift from a neighbor or take the new word
   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (at_slot) begin
            data_in = val;
         end else if (above_slot) begin
            data_in = left_data;
         end
      end else if (ctrl.del) begin
         if (at_slot || above_slot) begin
            data_in = right_data;
         end
      end
   end

   // read and compare results, taken from the entry before any shift
   always_comb begin
      rd_in  = (ctrl.rd && at_slot) ? data_ff : '0;
      hit_in = ctrl.srch && in_list && (data_ff == val);
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctrl.eval) begin
         rd_ff  <= rd_in;
         hit_ff <= hit_in;
      end
   end

   assign data    = data_ff;
   assign rd_data = rd_ff;
   assign hit     = hit_ff;

endmodule

FILE: rtl/positional_list_engine.sv
// Positional list engine top level: controller, cell row and response register.
// Sequencing: an accepted request passes through an evaluate state, where the
// row of cells shifts, reads and compares all entries, then a done state, which
// reduces the read data and match flags into the response register once the
// output is free; the next request is taken in the done state, not in evaluate.
// Reset: synchronous; clears the entry count and the handshake state, entries
// keep whatever they held and need no clearing pass.
module positional_list_engine import ple_pkg::*; #(
   parameter int CAPACITY   = PLE_CAPACITY,
   parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [6:0]  req_position,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_data_out,
   output logic [6:0]  rsp_found_index,
   output logic [6:0]  rsp_list_length
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DONE
   } state_type;

   state_type             state_ff;
   logic [1:0]            op_ff;
   logic [6:0]            pos_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [1:0]            stat_ff, stat_in;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [31:0]           rsp_data_ff;
   logic [6:0]            rsp_found_ff;
   logic [6:0]            rsp_length_ff;

   ple_ctrl_type          ctrl;
   logic [AW-1:0]         slot;
   logic                  pos_le_cnt, pos_nz, list_full;
   logic                  out_free, req_take;

   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
   logic [CAPACITY-1:0]   cell_hit;
   logic [DATA_WIDTH-1:0] rd_or;
   logic [CW-1:0]         hit_idx;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free);
   assign req_take  = req_valid && req_ready;

   // position checks against the current length
   assign pos_le_cnt = (CMPW'(pos_ff) <= CMPW'(count_ff));
   assign pos_nz     = (pos_ff != 7'd0);
   assign list_full  = (count_ff == CW'(CAPACITY));
   assign slot = (action_type'(op_ff) == ACT_INSERT) ? AW'(pos_ff) : AW'(pos_ff - 7'd1);

   // request decode into the cell command, status and next length
   always_comb begin
      ctrl     = '0;
      stat_in  = STAT_OK;
      count_in = count_ff;
      if (state_ff == ST_EVAL) begin
         ctrl.eval = 1'b1;
         unique case (action_type'(op_ff))
            ACT_INSERT: begin
               if (!pos_le_cnt) begin
                  stat_in = STAT_NOT_FOUND;
               end else if (list_full) begin
                  stat_in = STAT_FULL;
               end else begin
                  ctrl.ins = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            ACT_DELETE: begin
               if (pos_nz && pos_le_cnt) begin
                  ctrl.del = 1'b1;
                  ctrl.rd  = 1'b1;
                  count_in = count_ff - CW'(1);
               end else begin
                  stat_in = STAT_NOT_FOUND;
               end
            end
            ACT_FIND: begin
               if (pos_nz && pos_le_cnt) begin
                  ctrl.rd = 1'b1;
               end else begin
                  stat_in = STAT_NOT_FOUND;
               end
            end
            ACT_SEARCH: begin
               ctrl.srch = 1'b1;
            end
            default: begin
               stat_in = STAT_NOT_FOUND;
            end
         endcase
      end
   end

   // row of cells, each wired to its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = cell_data[i];
      end else begin : g_left
         assign left_w = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = cell_data[i];
      end else begin : g_right
         assign right_w = cell_data[i+1];
      end
      ple_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CAPACITY   (CAPACITY),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .slot       (slot),
         .count      (count_ff),
         .val        (val_ff),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i]),
         .hit        (cell_hit[i])
      );
   end

   // merge the one-hot read data and pick the first match
   always_comb begin
      rd_or   = '0;
      hit_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_or = rd_or | cell_rd[i];
      end
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (cell_hit[i]) begin
            hit_idx = CW'(i + 1);
         end
      end
   end

   // sequencer, length and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response valid: set when a response loads, cleared once taken
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               count_ff <= count_in;
               stat_ff  <= stat_in;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  if (action_type'(op_ff) == ACT_SEARCH) begin
                     rsp_status_ff <= (|cell_hit) ? STAT_OK : STAT_NOT_FOUND;
                  end else begin
                     rsp_status_ff <= stat_ff;
                  end
                  rsp_data_ff   <= 32'(rd_or);
                  rsp_found_ff  <= 7'(hit_idx);
                  rsp_length_ff <= 7'(count_ff);
                  state_ff      <= req_take ? ST_EVAL : ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      // request capture
      if (req_take) begin
         op_ff  <= req_action;
         pos_ff <= req_position;
         val_ff <= DATA_WIDTH'(req_value);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_list_length = rsp_length_ff;

endmodule

FILE: sim/tb.sv
// testbench for the positional list engine: directed and random requests checked by a scoreboard
`timescale 1ns / 1ps

module tb;
   import ple_pkg::*;

   localparam int CAP = PLE_CAPACITY;

   // expected fields of one response
   typedef struct {
      logic [1:0]  status;
      logic [31:0] data_out;
      logic [6:0]  found_index;
      logic [6:0]  list_length;
   } list_rsp_type;

   // shadow copy of the list plus the queue of responses still owed
   class list_scoreboard;
      logic [31:0]  words [CAP];
      int           count;
      list_rsp_type expected_rsp [$];
      int           mismatches;

      function void clear();
         count = 0;
         mismatches = 0;
         expected_rsp.delete();
         foreach (words[i]) words[i] = '0;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      // apply one accepted request to the shadow list and queue its response
      function void note_request(action_type act, logic [6:0] pos, logic [31:0] val);
         list_rsp_type r;
         int           hit;
         r.status = STAT_OK;
         r.data_out = '0;
         r.found_index = '0;
         hit = 0;
         case (act)
            ACT_INSERT: begin
               if (pos > count) begin
                  r.status = STAT_NOT_FOUND;
               end else if (count >= CAP) begin
                  r.status = STAT_FULL;
               end else begin
                  for (int i = count; i > pos; i--) words[i] = words[i-1];
                  words[pos] = val;
                  count++;
               end
            end
            ACT_DELETE: begin
               if (pos < 1 || pos > count) begin
                  r.status = STAT_NOT_FOUND;
               end else begin
                  r.data_out = words[pos-1];
                  for (int i = pos - 1; i + 1 < count; i++) words[i] = words[i+1];
                  count--;
               end
            end
            ACT_FIND: begin
               if (pos < 1 || pos > count) r.status = STAT_NOT_FOUND;
               else r.data_out = words[pos-1];
            end
            default: begin
               for (int i = 0; i < count; i++)
                  if (hit == 0 && words[i] == val) hit = i + 1;
               r.found_index = hit[6:0];
               if (hit == 0) r.status = STAT_NOT_FOUND;
            end
         endcase
         r.list_length = count[6:0];
         expected_rsp.push_back(r);
      endfunction

      // compare one accepted response with the oldest expectation
      function void check_response(logic [1:0] st, logic [31:0] dout, logic [6:0] fidx,
                                   logic [6:0] len);
         list_rsp_type e;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status=%0d data=%h index=%0d length=%0d",
                        st, dout, fidx, len);
            return;
         end
         e = expected_rsp.pop_front();
         if (st !== e.status || dout !== e.data_out || fidx !== e.found_index ||
             len !== e.list_length) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected status=%0d data=%h index=%0d length=%0d",
                        e.status, e.data_out, e.found_index, e.list_length,
                        ", got status=%0d data=%h index=%0d length=%0d",
                        st, dout, fidx, len);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ACT_INSERT;
   logic [6:0]  req_position = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_data_out;
   logic [6:0]  rsp_found_index;
   logic [6:0]  rsp_list_length;

   int tx_idle_pct = 22;
   int rx_idle_pct = 85;

   list_scoreboard sb = new();

   positional_list_engine uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_found_index (rsp_found_index),
      .rsp_list_length (rsp_list_length)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_data_out, rsp_found_index, rsp_list_length);
   end

   // present one request and hold it until accepted
   task automatic send_request(action_type act, logic [6:0] pos, logic [31:0] val);
      req_valid    <= 1'b1;
      req_action   <= act;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(act, pos, val);
   endtask

   // random sender gap ahead of a request
   task automatic issue(action_type act, logic [6:0] pos, logic [31:0] val);
      int gap;
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      send_request(act, pos, val);
   endtask

   // hold off until every owed response has arrived
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // one random request, biased toward growing or shrinking the list
   task automatic random_request(bit grow);
      action_type  act;
      logic [6:0]  pos;
      logic [31:0] val;
      int          r;
      int          cnt;
      cnt = sb.count;
      r = $urandom_range(0, 99);
      if (grow)
         act = (r < 70) ? ACT_INSERT : (r < 80) ? ACT_DELETE : (r < 90) ? ACT_FIND : ACT_SEARCH;
      else
         act = (r < 15) ? ACT_INSERT : (r < 70) ? ACT_DELETE : (r < 85) ? ACT_FIND : ACT_SEARCH;
      // mostly legal positions, some anywhere in range
      if ($urandom_range(0, 9) == 0 || (act != ACT_INSERT && cnt == 0))
         pos = 7'($urandom_range(0, 64));
      else if (act == ACT_INSERT)
         pos = 7'($urandom_range(0, cnt));
      else
         pos = 7'($urandom_range(1, cnt));
      // small values make duplicates, searches often target a stored word
      r = $urandom_range(0, 99);
      if (act == ACT_SEARCH && cnt > 0 && r < 60)
         val = sb.words[$urandom_range(0, cnt - 1)];
      else if (r < 80)
         val = $urandom();
      else if (r < 95)
         val = $urandom_range(0, 7);
      else
         val = 32'hFFFF_FFFF;
      issue(act, pos, val);
   endtask

   // stimulus
   initial begin
      sb.clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list corners
      issue(ACT_DELETE, 7'd0, 32'd0);
      issue(ACT_FIND, 7'd1, 32'd0);
      issue(ACT_SEARCH, 7'd0, 32'd0);
      issue(ACT_INSERT, 7'd1, 32'h1111_1111);
      // build a short list: front, after, middle, end
      issue(ACT_INSERT, 7'd0, 32'hFFFF_FFFF);
      issue(ACT_INSERT, 7'd1, 32'h0000_0000);
      issue(ACT_INSERT, 7'd0, 32'h8000_0001);
      issue(ACT_INSERT, 7'd2, 32'h5A5A_5A5A);
      issue(ACT_INSERT, 7'd4, 32'h0000_0001);
      // insert past the end
      issue(ACT_INSERT, 7'd6, 32'h2222_2222);
      issue(ACT_INSERT, 7'd64, 32'h3333_3333);
      // reads at both ends and out of range
      issue(ACT_FIND, 7'd1, 32'd0);
      issue(ACT_FIND, 7'd5, 32'd0);
      issue(ACT_FIND, 7'd0, 32'd0);
      issue(ACT_FIND, 7'd6, 32'd0);
      issue(ACT_FIND, 7'd64, 32'd0);
      // search hit, hit at extreme value, miss, first of duplicates
      issue(ACT_SEARCH, 7'd0, 32'h0000_0000);
      issue(ACT_SEARCH, 7'd64, 32'hFFFF_FFFF);
      issue(ACT_SEARCH, 7'd3, 32'h1234_5678);
      issue(ACT_INSERT, 7'd0, 32'h0000_0000);
      issue(ACT_SEARCH, 7'd0, 32'h0000_0000);
      // delete last, first, and out of range
      issue(ACT_DELETE, 7'd6, 32'd0);
      issue(ACT_DELETE, 7'd1, 32'd0);
      issue(ACT_DELETE, 7'd0, 32'd0);
      issue(ACT_DELETE, 7'd64, 32'd0);

      // three idling phases, each starting from a drained pipe
      for (int ph = 0; ph < 3; ph++) begin
         wait_for_drain();
         case (ph)
            0: begin tx_idle_pct = 22; rx_idle_pct = 85; end
            1: begin tx_idle_pct = 85; rx_idle_pct = 22; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         for (int n = 0; n < 300; n++)
            random_request(((ph * 300 + n) / 150) % 2 == 0);
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("positional_list_engine regression: pass");
      end else begin
         $display("positional_list_engine regression: fail");
      end
      $finish;
   end

   // run time limit
   initial begin
      #5_000_000;
      $display("positional_list_engine regression: fail");
      $finish;
   end

endmodule
